// File: rtl/core/nsa_pkg.sv
// Shared codes and types for the named slot allocator.
// No dependencies; imported by the allocator top level.
`default_nettype none

package nsa_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [1:0] FN_REGISTER   = 2'd0;
	localparam logic [1:0] FN_UNREGISTER = 2'd1;
	localparam logic [1:0] FN_QUERY      = 2'd2;

	// Result status codes carried on the output tuser.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_IN_USE    = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam int unsigned NAME_W = 64;
	localparam int unsigned OBJ_W  = 64;
	localparam int unsigned HW_W   = 9;

	// Name RAM entry: live flag above the name hash.
	typedef struct packed {
		logic              live;
		logic [NAME_W-1:0] name;
	} name_entry_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_EXEC = 6'b000100,
		S_POP  = 6'b001000,
		S_QRD  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/named_slot_allocator.sv
// Named slot allocator top level: sequencer, scan compare and result register.
// Depends on nsa_pkg and nsa_ram (name, object and free-stack stores).
//
// Each input beat carries an operation in tuser (register, unregister, query) and a
// 64-bit name hash plus object word in tdata. The block answers every beat with one
// result beat: status in tuser, the stored object and the high-water mark in tdata.
// Slot ids run from 1 to CAPACITY-1 and are handed out from a LIFO of freed ids
// first, then from the fresh-id counter. An undefined operation skips the lookup; for
// any other item the name lookup reads the name RAM through its single read port and
// checks one stored name per cycle, over the ids handed out so far, then S_EXEC acts
// on the slot, with S_POP to take a freed id off the stack or S_QRD to read the object.
// The block takes no new beat while an item is in work. A finished result waits in
// the output register, so the next beat is taken and worked meanwhile; that item
// holds in its last cycle until the earlier result is taken. No clearing pass after
// reset: ids at or above the fresh-id counter are treated as empty.
`default_nettype none

module named_slot_allocator
	import nsa_pkg::*;
#(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [127:0] s_tdata,  // [63:0] name_hash, [127:64] obj_value
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [79:0] m_tdata,   // [63:0] obj_out, [72:64] high_water, [79:73] zero
	output logic      [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	state_t state_q;

	logic [1:0]        func_q;
	logic [NAME_W-1:0] key_q;
	logic [OBJ_W-1:0]  obj_q;

	logic [CW-1:0] nf_q;          // next fresh id
	logic [CW-1:0] fc_q;          // free-stack fill
	logic [CW-1:0] scan_addr_q;
	logic          chk_vld_q;
	logic [IW-1:0] chk_slot_q;
	logic          found_q;
	logic [IW-1:0] slot_q;
	logic [1:0]        res_status_q;
	logic [OBJ_W-1:0]  res_obj_q;

	logic              m_tvalid_q;
	logic [1:0]        m_status_q;
	logic [OBJ_W-1:0]  m_obj_q;
	logic [HW_W-1:0]   m_hw_q;

	// RAM ports
	name_entry_t       name_rdata;
	name_entry_t       name_wdata;
	logic              name_we;
	logic [IW-1:0]     name_waddr;
	logic [OBJ_W-1:0]  obj_rdata;
	logic              obj_re;
	logic [IW-1:0]     stk_rdata;
	logic              stk_re;
	logic [IW-1:0]     stk_raddr;

	logic          issue;
	logic          hit;
	logic          exec_reg;
	logic          fresh_ok;
	logic          alloc_fresh;
	logic          alloc_pop;
	logic          unreg_hit;
	logic [CW-1:0] fc_dec;
	logic [CW+HW_W-1:0] hw_ext;
	logic [HW_W-1:0]    hw_now;

	assign fc_dec   = fc_q - ONE_C;
	assign fresh_ok = (nf_q < CAP_C);
	assign hw_ext   = {{HW_W{1'b0}}, nf_q};
	assign hw_now   = hw_ext[HW_W-1:0];

	always_comb begin
		issue       = (state_q == S_SCAN) && (scan_addr_q < nf_q);
		hit         = chk_vld_q && name_rdata.live && (name_rdata.name == key_q);
		exec_reg    = (state_q == S_EXEC) && (func_q == FN_REGISTER) && !found_q;
		alloc_fresh = exec_reg && (fc_q == '0) && fresh_ok;
		alloc_pop   = (state_q == S_POP);
		unreg_hit   = (state_q == S_EXEC) && (func_q == FN_UNREGISTER) && found_q;
		stk_re      = exec_reg && (fc_q != '0);
		stk_raddr   = fc_dec[IW-1:0];
		obj_re      = (state_q == S_EXEC) && (func_q == FN_QUERY) && found_q;
		name_we     = alloc_fresh || alloc_pop || unreg_hit;
		if (alloc_pop) begin
			name_waddr = stk_rdata;
		end else if (alloc_fresh) begin
			name_waddr = nf_q[IW-1:0];
		end else begin
			name_waddr = slot_q;
		end
		name_wdata.live = !unreg_hit;
		name_wdata.name = key_q;
	end

	// Object slots are only read on a live binding, so unregister leaves them as is.
	nsa_ram #(.WIDTH($bits(name_entry_t)), .DEPTH(CAPACITY)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_waddr),
		.wdata (name_wdata),
		.re    (issue),
		.raddr (scan_addr_q[IW-1:0]),
		.rdata (name_rdata)
	);

	nsa_ram #(.WIDTH(OBJ_W), .DEPTH(CAPACITY)) u_obj_ram (
		.clk   (clk),
		.we    (alloc_fresh || alloc_pop),
		.waddr (name_waddr),
		.wdata (obj_q),
		.re    (obj_re),
		.raddr (slot_q),
		.rdata (obj_rdata)
	);

	nsa_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_stack_ram (
		.clk   (clk),
		.we    (unreg_hit),
		.waddr (fc_q[IW-1:0]),
		.wdata (slot_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nf_q        <= ONE_C;
			fc_q        <= '0;
			scan_addr_q <= ONE_C;
			chk_vld_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					scan_addr_q <= ONE_C;
					chk_vld_q   <= 1'b0;
					if (s_tvalid) begin
						if (s_tuser inside {FN_REGISTER, FN_UNREGISTER, FN_QUERY}) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					chk_vld_q <= issue;
					if (issue) begin
						scan_addr_q <= scan_addr_q + ONE_C;
					end
					if (hit || !issue) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (func_q)
						FN_REGISTER: begin
							if (!found_q) begin
								if (fc_q != '0) begin
									fc_q    <= fc_dec;
									state_q <= S_POP;
								end else if (fresh_ok) begin
									nf_q <= nf_q + ONE_C;
								end
							end
						end
						FN_UNREGISTER: begin
							if (found_q) begin
								fc_q <= fc_q + ONE_C;
							end
						end
						FN_QUERY: begin
							if (found_q) begin
								state_q <= S_QRD;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_POP: begin
					state_q <= S_DONE;
				end
				S_QRD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q       <= s_tuser;
				key_q        <= s_tdata[63:0];
				obj_q        <= s_tdata[127:64];
				res_status_q <= ST_OK;
				res_obj_q    <= '0;
			end
			S_SCAN: begin
				chk_slot_q <= scan_addr_q[IW-1:0];
				if (hit) begin
					found_q <= 1'b1;
					slot_q  <= chk_slot_q;
				end else if (!issue) begin
					found_q <= 1'b0;
				end
			end
			S_EXEC: begin
				case (func_q)
					FN_REGISTER: begin
						if (found_q) begin
							res_status_q <= ST_IN_USE;
						end else if ((fc_q == '0) && !fresh_ok) begin
							res_status_q <= ST_LIMIT;
						end
					end
					FN_UNREGISTER, FN_QUERY: begin
						if (!found_q) begin
							res_status_q <= ST_NOT_FOUND;
						end
					end
					default: begin
						res_status_q <= ST_OK;
					end
				endcase
			end
			S_QRD: begin
				res_obj_q <= obj_rdata;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_status_q <= res_status_q;
					m_obj_q    <= res_obj_q;
					m_hw_q     <= hw_now;
				end
			end
			default: begin
				res_obj_q <= res_obj_q;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {7'b0, m_hw_q, m_obj_q};

	// Every freed id was handed out, so the stack never reaches the fresh counter.
	a_free_below_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q < nf_q)
		else $error("free stack fill not below next fresh id");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q >= ONE_C) && (nf_q <= CAP_C))
		else $error("next fresh id out of range");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_obj_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[63:0] != '0)) |-> (m_tuser == ST_OK))
		else $error("object returned with a failing status");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && hit) |-> (CW'(chk_slot_q) < nf_q))
		else $error("name match outside handed-out ids");

endmodule

`default_nettype wire

// File: rtl/core/nsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; used for every store of the slot allocator.
`default_nettype none

module nsa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
